### sv/sfod_pkg.sv
// ----------------------------------------------------------------------------
// sfod_pkg
// Shared constants, widths and types of the spectral flux onset detector.
// ----------------------------------------------------------------------------
package sfod_pkg;

  localparam int DIFF_FRAMES_DEF   = 2;
  localparam int MAX_WINDOW_DEF    = 3;
  localparam int HISTORY_DEPTH_DEF = 64;
  localparam int MAX_BANDS_DEF     = 32;

  localparam int BAND_VALUE_W = 24;
  localparam int SUM_W        = 29;
  localparam int CFG_W        = 6;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 64;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;
  localparam int REG_IDX_W    = APB_ADDR_W - 2;

  localparam logic [CFG_W-1:0]     BAND_COUNT_RST = 6'd24;
  localparam logic [REG_IDX_W-1:0] REG_BAND_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUM,
    ST_HSCAN,
    ST_EMIT
  } sfod_state_t;

endpackage

### sv/sfod_ram.sv
// ----------------------------------------------------------------------------
// sfod_ram
// Simple dual-port synchronous RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module sfod_ram #(
  parameter int  WIDTH = 24,
  parameter int  DEPTH = 96,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/spectral_flux_onset_detector_unit.sv
// ----------------------------------------------------------------------------
// spectral_flux_onset_detector_unit
// Spectral flux onset detector: max-filtered frame difference, onset history.
// ----------------------------------------------------------------------------
//  channel | dir | beat                   | payload
//  in_     | in  | one band energy        | tdata[23:0] band_value
//  out_    | out | one result per frame   | tdata[28:0] onset_value,
//          |     |                        | tdata[57:29] history_max
//  cfg_    | in  | APB register access    | reg 0 @ 0x0: band_count[5:0]
//
//  A band takes one frame memory read for itself and one per band of its
//  window through the single read port, then a sum step. The last band of
//  a frame also sweeps the history memory one entry a cycle for the maximum.
//  Reset clears the state, pointers, flux sum, output valid and the
//  per-entry valid bits at once; no clearing pass. A stalled result holds
//  in the output register while the next bands of the following frame
//  are taken.
// ----------------------------------------------------------------------------
module spectral_flux_onset_detector_unit #(
  parameter int DIFF_FRAMES   = sfod_pkg::DIFF_FRAMES_DEF,
  parameter int MAX_WINDOW    = sfod_pkg::MAX_WINDOW_DEF,
  parameter int HISTORY_DEPTH = sfod_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_BANDS     = sfod_pkg::MAX_BANDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [sfod_pkg::APB_ADDR_W-1:0]   cfg_paddr,
  input  logic [sfod_pkg::APB_DATA_W-1:0]   cfg_pwdata,
  output logic [sfod_pkg::APB_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sfod_pkg::IN_TDATA_W-1:0]   in_tdata,   // [23:0] band_value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sfod_pkg::OUT_TDATA_W-1:0]  out_tdata   // [28:0] onset_value,
                                                        // [57:29] history_max
);
  import sfod_pkg::*;

  localparam int RING_FRAMES = DIFF_FRAMES + 1;
  localparam int RING_DEPTH  = RING_FRAMES * MAX_BANDS;
  localparam int RA_W        = $clog2(RING_DEPTH);
  localparam int FW          = $clog2(RING_FRAMES);
  localparam int BW          = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int HALF        = MAX_WINDOW / 2;
  localparam int KW          = $clog2(MAX_BANDS + HALF + 2);
  localparam int HW          = $clog2(HISTORY_DEPTH);
  localparam int HCW         = $clog2(HISTORY_DEPTH + 1);

  sfod_state_t state_r, state_nxt;

  logic [CFG_W-1:0]        band_count_r;
  logic [FW-1:0]           wf_r, wf_nxt;
  logic [BW-1:0]           pos_r, pos_nxt;
  logic [SUM_W-1:0]        flux_r, flux_nxt;
  logic [BAND_VALUE_W-1:0] val_r, val_nxt;
  logic [BAND_VALUE_W-1:0] m_r, m_nxt;
  logic [KW-1:0]           k_r, k_nxt;
  logic [KW-1:0]           hi_r, hi_nxt;
  logic [KW-1:0]           cnt_r, cnt_nxt;
  logic [HCW-1:0]          hidx_r, hidx_nxt;
  logic [SUM_W-1:0]        hmax_r, hmax_nxt;
  logic [HW-1:0]           hwp_r, hwp_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]        out_onset_r, out_onset_nxt;
  logic [SUM_W-1:0]        out_hmax_r, out_hmax_nxt;
  logic                    rvld_r, hrvld_r;
  logic [RING_DEPTH-1:0]   ring_vld_r;
  logic [HISTORY_DEPTH-1:0] hist_vld_r;

  logic                    in_beat, cfg_wr;
  logic [BAND_VALUE_W-1:0] band_value;
  logic [KW-1:0]           count_c, pos_k, lo_c, hi_raw, hi_c;
  logic [FW-1:0]           old_f, wf_inc;
  logic [BW-1:0]           rd_band;
  logic [RA_W-1:0]         ring_wa, ring_ra;
  logic                    ring_we, ring_re;
  logic [BAND_VALUE_W-1:0] ring_rdata, ring_q, m_abs, excess;
  logic [SUM_W:0]          sum_ext;
  logic [SUM_W-1:0]        flux_new;
  logic                    last_band;
  logic                    hist_we, hist_re;
  logic [HW-1:0]           hist_ra, hwp_inc;
  logic [SUM_W-1:0]        hist_rdata, hist_q, h_abs;
  logic                    out_free;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready &
                      (cfg_paddr[APB_ADDR_W-1:2] == REG_BAND_COUNT);
  assign cfg_prdata = (cfg_paddr[APB_ADDR_W-1:2] == REG_BAND_COUNT) ?
                      APB_DATA_W'(band_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_count_r <= BAND_COUNT_RST;
    end else if (cfg_wr) begin
      band_count_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  // Stream ports
  assign in_tready  = (state_r == ST_IDLE);
  assign in_beat    = in_tvalid & in_tready;
  assign band_value = in_tdata[BAND_VALUE_W-1:0];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2*SUM_W){1'b0}}, out_hmax_r, out_onset_r};
  assign out_free   = ~out_valid_r | out_tready;

  // Band window
  assign count_c = (32'(band_count_r) > 32'(MAX_BANDS)) ? KW'(MAX_BANDS)
                                                        : KW'(band_count_r);
  assign pos_k   = KW'(pos_r);
  assign lo_c    = (pos_k > KW'(HALF)) ? pos_k - KW'(HALF) : '0;
  assign hi_raw  = pos_k + KW'(HALF + 1);
  assign hi_c    = (hi_raw > count_c) ? count_c : hi_raw;

  assign wf_inc  = (wf_r == FW'(RING_FRAMES - 1)) ? '0 : wf_r + 1'b1;
  assign old_f   = wf_inc;
  assign ring_we = in_beat & (count_c != '0);
  assign ring_wa = RA_W'(32'(wf_r) * MAX_BANDS + 32'(pos_r));
  assign ring_ra = RA_W'(32'(old_f) * MAX_BANDS + 32'(rd_band));
  assign ring_q  = rvld_r ? ring_rdata : '0;
  assign m_abs   = (ring_q > m_r) ? ring_q : m_r;

  assign excess    = (val_r > m_r) ? val_r - m_r : '0;
  assign sum_ext   = {1'b0, flux_r} + (SUM_W + 1)'(excess);
  assign flux_new  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign last_band = (pos_k + KW'(1)) >= cnt_r;

  assign hwp_inc = (hwp_r == HW'(HISTORY_DEPTH - 1)) ? '0 : hwp_r + 1'b1;
  assign hist_ra = hidx_r[HW-1:0];
  assign hist_q  = hrvld_r ? hist_rdata : '0;
  assign h_abs   = (hist_q > hmax_r) ? hist_q : hmax_r;

  sfod_ram #(
    .WIDTH (BAND_VALUE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_wa),
    .wr_data (band_value),
    .rd_en   (ring_re),
    .rd_addr (ring_ra),
    .rd_data (ring_rdata)
  );

  sfod_ram #(
    .WIDTH (SUM_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (hwp_r),
    .wr_data (flux_new),
    .rd_en   (hist_re),
    .rd_addr (hist_ra),
    .rd_data (hist_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    wf_nxt        = wf_r;
    pos_nxt       = pos_r;
    flux_nxt      = flux_r;
    val_nxt       = val_r;
    m_nxt         = m_r;
    k_nxt         = k_r;
    hi_nxt        = hi_r;
    cnt_nxt       = cnt_r;
    hidx_nxt      = hidx_r;
    hmax_nxt      = hmax_r;
    hwp_nxt       = hwp_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_onset_nxt = out_onset_r;
    out_hmax_nxt  = out_hmax_r;
    ring_re       = 1'b0;
    rd_band       = pos_r;
    hist_we       = 1'b0;
    hist_re       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (ring_we) begin
          val_nxt   = band_value;
          m_nxt     = '0;
          k_nxt     = lo_c;
          hi_nxt    = hi_c;
          cnt_nxt   = count_c;
          ring_re   = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        m_nxt = m_abs;
        if (k_r < hi_r) begin
          ring_re = 1'b1;
          rd_band = k_r[BW-1:0];
          k_nxt   = k_r + 1'b1;
        end else begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        flux_nxt = flux_new;
        if (!last_band) begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          hist_we   = 1'b1;
          hwp_nxt   = hwp_inc;
          hidx_nxt  = '0;
          hmax_nxt  = '0;
          state_nxt = ST_HSCAN;
        end
      end
      ST_HSCAN: begin
        hmax_nxt = h_abs;
        if (hidx_r < HCW'(HISTORY_DEPTH)) begin
          hist_re  = 1'b1;
          hidx_nxt = hidx_r + 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_onset_nxt = flux_r;
          out_hmax_nxt  = (hmax_r == '0) ? SUM_W'(1) : hmax_r;
          flux_nxt      = '0;
          pos_nxt       = '0;
          wf_nxt        = wf_inc;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wf_r        <= '0;
      pos_r       <= '0;
      flux_r      <= '0;
      hwp_r       <= '0;
      out_valid_r <= 1'b0;
      ring_vld_r  <= '0;
      hist_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      wf_r        <= wf_nxt;
      pos_r       <= pos_nxt;
      flux_r      <= flux_nxt;
      hwp_r       <= hwp_nxt;
      out_valid_r <= out_valid_nxt;
      if (ring_we) begin
        ring_vld_r[ring_wa] <= 1'b1;
      end
      if (hist_we) begin
        hist_vld_r[hwp_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    m_r         <= m_nxt;
    k_r         <= k_nxt;
    hi_r        <= hi_nxt;
    cnt_r       <= cnt_nxt;
    hidx_r      <= hidx_nxt;
    hmax_r      <= hmax_nxt;
    out_onset_r <= out_onset_nxt;
    out_hmax_r  <= out_hmax_nxt;
    rvld_r      <= ring_re & ring_vld_r[ring_ra];
    hrvld_r     <= hist_re & hist_vld_r[hist_ra];
  end

endmodule

### sv/sfod_checker.sv
// ----------------------------------------------------------------------------
// sfod_checker
// Port-level checks of the onset detector, bound to the top level.
// ----------------------------------------------------------------------------
module sfod_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              cfg_psel,
  input logic                              cfg_penable,
  input logic                              cfg_pwrite,
  input logic [sfod_pkg::APB_ADDR_W-1:0]   cfg_paddr,
  input logic [sfod_pkg::APB_DATA_W-1:0]   cfg_pwdata,
  input logic [sfod_pkg::APB_DATA_W-1:0]   cfg_prdata,
  input logic                              cfg_pready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [sfod_pkg::OUT_TDATA_W-1:0]  out_tdata   // [28:0] onset_value,
                                                       // [57:29] history_max
);
  import sfod_pkg::*;

  logic [SUM_W-1:0] onset_f, hmax_f;
  logic             cfg_wr_beat;

  assign onset_f     = out_tdata[SUM_W-1:0];
  assign hmax_f      = out_tdata[2*SUM_W-1:SUM_W];
  assign cfg_wr_beat = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready &
                       (cfg_paddr[APB_ADDR_W-1:2] == REG_BAND_COUNT);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  a_hmax_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> hmax_f != '0)
    else $error("history maximum below one LSB");

  a_hmax_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> hmax_f >= onset_f)
    else $error("history maximum below its own onset value");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_beat |=> (cfg_paddr[APB_ADDR_W-1:2] != REG_BAND_COUNT) ||
                    (cfg_prdata[CFG_W-1:0] == $past(cfg_pwdata[CFG_W-1:0])))
    else $error("band count readback differs from written value");

endmodule

bind spectral_flux_onset_detector_unit sfod_checker u_sfod_checker (.*);

### verif/spectral_flux_onset_detector_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spectral_flux_onset_detector_unit_tb
// Self-checking bench for the spectral flux onset detector. Band energies
// are streamed in under several band counts and idle patterns. A behavioural
// model of the frame ring, the neighbour maximum and the onset history
// predicts each per-frame result, which is compared with the block's output
// beats in order. The band count register is also read back over APB.
// ----------------------------------------------------------------------------
module spectral_flux_onset_detector_unit_tb;
  import sfod_pkg::*;

  localparam int RING_FRAMES   = DIFF_FRAMES_DEF + 1;
  localparam int HALF_WINDOW   = MAX_WINDOW_DEF / 2;
  localparam int SETTLE_CYCLES = (MAX_WINDOW_DEF + 3) * 4 + HISTORY_DEPTH_DEF + 32;
  localparam logic [SUM_W-1:0]     SUM_MAX    = '1;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 1'b1;

  typedef struct packed {
    logic [SUM_W-1:0] onset;
    logic [SUM_W-1:0] peak;
  } onset_result_t;

  class onset_predictor;
    logic [CFG_W-1:0]        band_count;
    logic [BAND_VALUE_W-1:0] frame_ring [RING_FRAMES][MAX_BANDS_DEF];
    int unsigned             write_slot;
    int unsigned             band_pos;
    logic [SUM_W-1:0]        flux_acc;
    logic [SUM_W-1:0]        history [HISTORY_DEPTH_DEF];
    onset_result_t           expected_onsets [$];
    int                      errors;

    function new();
      band_count = BAND_COUNT_RST;
      write_slot = 0;
      band_pos   = 0;
      flux_acc   = '0;
      errors     = 0;
      foreach (frame_ring[f, b]) frame_ring[f][b] = '0;
      foreach (history[i]) history[i] = '0;
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 10)
        $display("mismatch in %0s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
    endfunction

    function int pending();
      return expected_onsets.size();
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] data);
      if (idx == REG_BAND_COUNT) band_count = data[CFG_W-1:0];
    endfunction

    function void check_readback(logic [APB_DATA_W-1:0] data);
      logic [APB_DATA_W-1:0] want;
      want = '0;
      want[CFG_W-1:0] = band_count;
      if (data !== want) flag("band_count readback", want, data);
    endfunction

    function void take_band(logic [BAND_VALUE_W-1:0] val);
      int unsigned             count, pos, old, lo, hi, k;
      logic [BAND_VALUE_W-1:0] ceiling;
      logic [SUM_W-1:0]        excess, peak;
      onset_result_t           r;
      count = band_count;
      if (count == 0) return;
      if (count > MAX_BANDS_DEF) count = MAX_BANDS_DEF;
      pos = (band_pos >= MAX_BANDS_DEF) ? MAX_BANDS_DEF - 1 : band_pos;
      frame_ring[write_slot][pos] = val;
      old = (write_slot + 1) % RING_FRAMES;
      lo  = (pos > HALF_WINDOW) ? pos - HALF_WINDOW : 0;
      hi  = pos + HALF_WINDOW + 1;
      if (hi > count) hi = count;
      ceiling = frame_ring[old][pos];
      for (k = lo; k < hi; k++)
        if (frame_ring[old][k] > ceiling) ceiling = frame_ring[old][k];
      if (val > ceiling) begin
        excess   = SUM_W'(val) - SUM_W'(ceiling);
        flux_acc = (flux_acc > SUM_MAX - excess) ? SUM_MAX : flux_acc + excess;
      end
      if (pos + 1 < count) begin
        band_pos = pos + 1;
        return;
      end
      for (k = 0; k < HISTORY_DEPTH_DEF - 1; k++) history[k] = history[k + 1];
      history[HISTORY_DEPTH_DEF - 1] = flux_acc;
      peak = history[0];
      for (k = 1; k < HISTORY_DEPTH_DEF; k++)
        if (history[k] > peak) peak = history[k];
      if (peak < 1) peak = 1;
      r.onset = flux_acc;
      r.peak  = peak;
      expected_onsets.push_back(r);
      flux_acc   = '0;
      band_pos   = 0;
      write_slot = (write_slot + 1) % RING_FRAMES;
    endfunction

    function void check_onset(logic [OUT_TDATA_W-1:0] data);
      onset_result_t want;
      if (expected_onsets.size() == 0) begin
        flag("unexpected onset_value", '0, data[SUM_W-1:0]);
        return;
      end
      want = expected_onsets.pop_front();
      if (data[SUM_W-1:0] !== want.onset)
        flag("onset_value", want.onset, data[SUM_W-1:0]);
      if (data[2*SUM_W-1:SUM_W] !== want.peak)
        flag("history_max", want.peak, data[2*SUM_W-1:SUM_W]);
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [APB_ADDR_W-1:0]  cfg_paddr;
  logic [APB_DATA_W-1:0]  cfg_pwdata;
  logic [APB_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // [23:0] band_value
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // [28:0] onset_value, [57:29] history_max

  onset_predictor predictor = new();
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  int             holdoff_left   = 0;

  spectral_flux_onset_detector_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) predictor.check_onset(out_tdata);
      if (in_tvalid && in_tready) predictor.take_band(in_tdata[BAND_VALUE_W-1:0]);
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite)
          predictor.write_reg(cfg_paddr[APB_ADDR_W-1:2], cfg_pwdata);
        else if (cfg_paddr[APB_ADDR_W-1:2] == REG_BAND_COUNT)
          predictor.check_readback(cfg_prdata);
      end
    end
  end

  // hold the result side off for a counted stretch, else stall at random
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      out_tready = 1'b0;
      holdoff_left--;
    end else begin
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [BAND_VALUE_W-1:0] pick_band();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return BAND_VALUE_W'(r[11:0]);
      4:       return BAND_VALUE_W'(r[17:0]);
      default: return r[BAND_VALUE_W-1:0];
    endcase
  endfunction

  task automatic send_band(logic [BAND_VALUE_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = val;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (predictor.pending() != 0) @(negedge clk);
  endtask

  task automatic apb_access(logic write, logic [REG_IDX_W-1:0] idx,
                            logic [APB_DATA_W-1:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = write;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic set_band_count(logic [CFG_W-1:0] n, logic [REG_IDX_W-1:0] idx);
    logic [APB_DATA_W-1:0] wdata;
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    wdata = $urandom();
    wdata[CFG_W-1:0] = n;
    apb_access(1'b1, idx, wdata);
    apb_access(1'b0, REG_BAND_COUNT, '0);
  endtask

  initial begin
    int phase_counts [14] = '{32, 63, 2, 1, 0, 9, 33, 24, 3, -1, 31, 17, -1, 5};
    int count, items;
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    apb_access(1'b0, REG_BAND_COUNT, '0);

    // extremes over three frames, so the third sees the first
    set_band_count(6'd3, REG_BAND_COUNT);
    send_band(24'h000000); send_band(24'hFFFFFF); send_band(24'h000000);
    send_band(24'hFFFFFF); send_band(24'hFFFFFF); send_band(24'hFFFFFF);
    send_band(24'h000001); send_band(24'h800000); send_band(24'hFFFFFF);

    // zero band count: beats are dropped
    set_band_count(6'd0, REG_BAND_COUNT);
    send_band(24'hFFFFFF); send_band(24'h123456);

    set_band_count(6'd7, REG_UNUSED);
    set_band_count(6'd1, REG_BAND_COUNT);
    send_band(24'hFFFFFF); send_band(24'h000000); send_band(24'h000FFF);

    // lower the count mid-frame: the next beat closes the frame
    set_band_count(6'd5, REG_BAND_COUNT);
    send_band(24'h123456); send_band(24'hABCDEF); send_band(24'h7FFFFF);
    set_band_count(6'd2, REG_BAND_COUNT);
    send_band(24'h555555); send_band(24'hAAAAAA); send_band(24'h000001);

    for (int p = 0; p < 14; p++) begin
      count = (phase_counts[p] < 0) ? $urandom_range(1, 63) : phase_counts[p];
      set_band_count(CFG_W'(count), REG_BAND_COUNT);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
      endcase
      if (count == 0)      items = 6;
      else if (count == 1) items = 60;
      else                 items = $urandom_range(120, 180);
      if (p == 2) holdoff_left = 800;
      for (int n = 0; n < items; n++) begin
        if (p == 5 && n == items / 2) drain_results();
        send_band(pick_band());
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (predictor.errors == 0 && predictor.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
